// ===== rtl/pid_remap_table_macros.svh =====
// Assertion macros shared by the checker of the identifier remap table.
// No dependencies; included by the files that assert.
`ifndef PID_REMAP_TABLE_MACROS_SVH
`define PID_REMAP_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PIDRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PIDRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pidrt_pkg.sv =====
// Shared types and operation codes for the identifier remap table.
// No dependencies.
package pidrt_pkg;

   localparam int PID_W = 13;

   typedef logic [PID_W-1:0] pid_type;
   typedef logic [1:0]       func_type;

   localparam func_type FUNC_LOOKUP = 2'd0;
   localparam func_type FUNC_ADD    = 2'd1;
   localparam func_type FUNC_DELETE = 2'd2;

   // One table slot: original identifier and its replacement.
   typedef struct packed {
      pid_type src;
      pid_type tgt;
   } slot_type;

endpackage

// ===== rtl/pidrt_mem.sv =====
// Slot store: one write port, one read port with registered read data.
// Depends on pidrt_pkg for the slot layout.
module pidrt_mem #(
   parameter int ENTRIES = 32,
   parameter int AW      = 5
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  pidrt_pkg::slot_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output pidrt_pkg::slot_type rd_data
);
   import pidrt_pkg::*;

   slot_type mem_ff [ENTRIES];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pid_remap_table.sv =====
// Top level of the identifier remap table: sequencer, shared comparator, result register.
// Depends on pidrt_pkg and pidrt_mem.
//
//   channel | dir | tdata                         | tuser
//   req     | in  | source_pid, target_pid        | func
//   rsp     | out | mapped_pid                    | ok
//
// A lookup, add or delete scans the slots one per cycle through the single read port
// and comparator; a zero source_pid or an unused func skips the scan and goes straight
// to the response with ok low. After reset a clearing pass writes every slot, with
// req_tready low. A result waits in the output register; a stalled rsp only delays
// the end of the following transaction.
module pid_remap_table #(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // source_pid[12:0], target_pid[25:13], zero[31:26]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // mapped_pid[12:0], zero[15:13]
   output logic        rsp_tuser    // ok[0]
);
   import pidrt_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   func_type         func_ff, func_in;
   pid_type          src_ff, src_in;
   pid_type          tgt_ff, tgt_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic             rd_done_ff, rd_done_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]    cmp_addr_ff, cmp_addr_in;
   logic             ok_ff, ok_in;
   pid_type          mapped_ff, mapped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   pid_type          rsp_pid_ff, rsp_pid_in;

   logic             req_accept;
   logic             issue;
   logic             hit;
   pid_type          key;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   slot_type         wr_data;
   slot_type         rd_data;

   pidrt_mem #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // add hunts for a free slot, the others for the source identifier
   assign key   = (func_ff == FUNC_ADD) ? '0 : src_ff;
   assign issue = (state_ff == ST_SCAN) & ~rd_done_ff;
   assign hit   = (state_ff == ST_SCAN) & cmp_valid_ff & (rd_data.src == key);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (hit && (func_ff != FUNC_LOOKUP)) begin
         wr_en   = 1'b1;
         wr_addr = cmp_addr_ff;
         if (func_ff == FUNC_ADD) begin
            wr_data.src = src_ff;
            wr_data.tgt = tgt_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      addr_in      = addr_ff;
      rd_done_in   = rd_done_ff;
      cmp_valid_in = issue;
      cmp_addr_in  = addr_ff;
      ok_in        = ok_ff;
      mapped_in    = mapped_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pid_in   = rsp_pid_ff;

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               func_in    = req_tuser;
               src_in     = req_tdata[PID_W-1:0];
               tgt_in     = req_tdata[2*PID_W-1:PID_W];
               addr_in    = '0;
               rd_done_in = 1'b0;
               ok_in      = 1'b0;
               mapped_in  = '0;
               if ((req_tdata[PID_W-1:0] == '0) ||
                   ((req_tuser != FUNC_LOOKUP) && (req_tuser != FUNC_ADD) &&
                    (req_tuser != FUNC_DELETE))) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               if (addr_ff == LAST) begin
                  rd_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
            if (hit) begin
               ok_in = 1'b1;
               if (func_ff == FUNC_LOOKUP) begin
                  mapped_in = rd_data.tgt;
               end
               state_in = ST_RESP;
            end else if (cmp_valid_ff && (cmp_addr_ff == LAST)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_pid_in   = mapped_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rd_done_ff   <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_done_ff   <= rd_done_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      cmp_addr_ff <= cmp_addr_in;
      ok_ff       <= ok_in;
      mapped_ff   <= mapped_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_pid_ff  <= rsp_pid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-PID_W){1'b0}}, rsp_pid_ff};
   assign rsp_tuser  = rsp_ok_ff;

endmodule

// ===== rtl/pidrt_checker.sv =====
// Port-level checks for the identifier remap table, bound to the top level.
// Depends on pidrt_pkg and pid_remap_table_macros.svh.
`include "pid_remap_table_macros.svh"

module pidrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);
   import pidrt_pkg::*;

   // a stalled result holds still
   `PIDRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")

   // one transaction at a time: busy right after an accept
   `PIDRT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "req_tready high right after accept")

   // failed operations carry a zero identifier
   `PIDRT_ASSERT_NOW(a_fail_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[PID_W-1:0] == '0, "failed result with nonzero mapped_pid")

   // a new result appears exactly as the sequencer returns to idle
   `PIDRT_ASSERT_NOW(a_rsp_at_idle, clock, reset, $rose(rsp_tvalid), req_tready, "result raised while busy")

endmodule

bind pid_remap_table pidrt_checker u_pidrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
